@@ src/mtep_pkg.sv @@
// Shared types and codes for the MIDI track event parser.
// Used by mtep_core, mtep_out and the top level; no dependencies.
package mtep_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [KIND_W-1:0] KIND_NOTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNSUP   = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic [DATA_W-1:0] note_number;
    logic [DATA_W-1:0] velocity;
    logic [TIME_W-1:0] abs_time;
  } result_t;

endpackage

@@ src/mtep_core.sv @@
// Input byte register, parser state and per-byte update logic.
// Depends on mtep_pkg; feeds a valid result_t to mtep_out for each byte that yields an event.
module mtep_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            res_ready,
  output mtep_pkg::result_t res
);
  import mtep_pkg::*;

  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_DELTA     = 4'd1;
  localparam logic [3:0] PH_STATUS    = 4'd2;
  localparam logic [3:0] PH_META_TYPE = 4'd3;
  localparam logic [3:0] PH_META_LEN  = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_NOTE1     = 4'd6;
  localparam logic [3:0] PH_NOTE2     = 4'd7;
  localparam logic [3:0] PH_ERRSKIP   = 4'd8;

  // Status byte codes (high nibble unless noted)
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_POLY      = 4'hA;
  localparam logic [3:0] ST_CTRL      = 4'hB;
  localparam logic [3:0] ST_PROG      = 4'hC;
  localparam logic [3:0] ST_CHPRESS   = 4'hD;
  localparam logic [3:0] ST_BEND      = 4'hE;

  logic              in_vld_r;
  logic [DATA_W-1:0] in_byte_r;
  logic              fire;

  logic [3:0]        phase_r, phase_nxt;
  logic [2:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [TIME_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [TIME_W-1:0] delta_r, delta_nxt;
  logic [TIME_W-1:0] run_time_r, run_time_nxt;
  logic [7:0]        skip_cnt_r, skip_cnt_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [DATA_W-1:0] first_r, first_nxt;

  logic              done;
  logic              kind_vld;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] b;
  logic [3:0]        hi_nib;

  assign fire      = in_vld_r && res_ready;
  assign in_tready = !in_vld_r || res_ready;
  assign b         = in_byte_r;
  assign hi_nib    = in_byte_r[7:4];

  // Hold the byte until the result slot can take its outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    bytes_left_nxt = bytes_left_r;
    delta_nxt      = delta_r;
    run_time_nxt   = run_time_r;
    skip_cnt_nxt   = skip_cnt_r;
    chan_nxt       = chan_r;
    first_nxt      = first_r;
    done           = 1'b0;
    kind_vld       = 1'b0;
    kind           = KIND_END;

    if (phase_r == PH_HEADER || phase_r > PH_ERRSKIP) begin
      phase_nxt = PH_HEADER;
      if (hdr_cnt_r[2]) begin
        bytes_left_nxt = {bytes_left_r[TIME_W-9:0], b};
      end
      hdr_cnt_nxt = hdr_cnt_r + 3'd1;
      if (hdr_cnt_r == 3'd7) begin
        run_time_nxt = '0;
        delta_nxt    = '0;
        if (bytes_left_nxt == '0) begin
          kind_vld = 1'b1;
          kind     = KIND_END;
        end else begin
          phase_nxt = PH_DELTA;
        end
      end
    end else begin
      bytes_left_nxt = bytes_left_r - 32'd1;
      unique case (phase_r)
        PH_DELTA: begin
          delta_nxt = {delta_r[TIME_W-8:0], b[6:0]};
          if (!b[7]) begin
            run_time_nxt = run_time_r + delta_nxt;
            delta_nxt    = '0;
            phase_nxt    = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b == ST_META) begin
            phase_nxt = PH_META_TYPE;
          end else if (hi_nib == ST_CTRL || hi_nib == ST_PROG || hi_nib == ST_CHPRESS) begin
            skip_cnt_nxt = 8'd1;
            phase_nxt    = PH_SKIP;
          end else if (hi_nib == ST_NOTE_OFF || hi_nib == ST_POLY || hi_nib == ST_BEND) begin
            skip_cnt_nxt = 8'd2;
            phase_nxt    = PH_SKIP;
          end else if (hi_nib == ST_NOTE_ON) begin
            chan_nxt  = b[3:0];
            phase_nxt = PH_NOTE1;
          end else begin
            kind_vld  = 1'b1;
            kind      = KIND_UNSUP;
            phase_nxt = PH_ERRSKIP;
          end
        end
        PH_META_TYPE: phase_nxt = PH_META_LEN;
        PH_META_LEN: begin
          skip_cnt_nxt = b;
          if (b == 8'd0) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_cnt_nxt = skip_cnt_r - 8'd1;
          done         = (skip_cnt_nxt == 8'd0);
        end
        PH_NOTE1: begin
          first_nxt = b;
          phase_nxt = PH_NOTE2;
        end
        PH_NOTE2: begin
          kind_vld = 1'b1;
          kind     = KIND_NOTE;
          done     = 1'b1;
        end
        default: ; // error skip: drop bytes until the chunk ends
      endcase

      if (done) begin
        phase_nxt = PH_DELTA;
      end

      if (bytes_left_nxt == '0) begin
        if (!kind_vld) begin
          kind_vld = 1'b1;
          kind     = (done || phase_nxt == PH_ERRSKIP) ? KIND_END : KIND_OVERRUN;
        end
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      bytes_left_r <= '0;
      delta_r      <= '0;
      run_time_r   <= '0;
      skip_cnt_r   <= '0;
      chan_r       <= '0;
      first_r      <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      delta_r      <= delta_nxt;
      run_time_r   <= run_time_nxt;
      skip_cnt_r   <= skip_cnt_nxt;
      chan_r       <= chan_nxt;
      first_r      <= first_nxt;
    end
  end

  always_comb begin
    res.valid       = fire && kind_vld;
    res.kind        = kind;
    res.channel     = (kind == KIND_NOTE) ? chan_r : '0;
    res.note_number = (kind == KIND_NOTE) ? first_r : '0;
    res.velocity    = (kind == KIND_NOTE) ? b : '0;
    res.abs_time    = run_time_nxt;
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_ERRSKIP)
    else $error("parser phase out of range");

  a_hdr_cnt_body: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HEADER |-> hdr_cnt_r == 3'd0)
    else $error("header count not cleared in chunk body");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_cnt_r != 8'd0)
    else $error("skip phase with zero count");

  a_note_origin: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == KIND_NOTE |-> phase_r == PH_NOTE2)
    else $error("note-on result outside velocity byte");

  a_empty_time: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && phase_r == PH_HEADER |-> res.abs_time == '0)
    else $error("header result with nonzero time");

endmodule

@@ src/mtep_out.sv @@
// Result register for the MIDI track event parser.
// Depends on mtep_pkg; holds one result until the consumer takes it.
module mtep_out (
  input  logic              clk,
  input  logic              rst_n,
  input  mtep_pkg::result_t res,
  output logic              res_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,
  output logic [1:0]        out_tuser
);
  import mtep_pkg::*;

  logic    out_vld_r;
  result_t out_r;

  assign res_ready  = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {{(OUT_DATA_W - TIME_W - 2*DATA_W - CHAN_W){1'b0}},
                       out_r.abs_time, out_r.velocity, out_r.note_number, out_r.channel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (res.valid) begin
      out_r <= res;
    end
  end

endmodule

@@ src/midi_track_event_parser.sv @@
// MIDI track chunk parser: one byte of the chunk in; note-on, chunk end, overrun and unsupported-status events out.
// A byte accepted into the byte register shows its result, if any, from the result register.
// Throughput: one byte per cycle while out_tready stays high; a waiting result lets one
//   more byte into the byte register, then any byte stalls until out_tready returns.
// Reset (rst_n low, synchronous): parser expects a chunk tag, counts and
//   running time clear, both pipeline registers empty.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] channel, [11:4] note_number,
                                  // [19:12] velocity, [51:20] abs_time, [55:52] zero
  output logic [1:0]  out_tuser   // [1:0] kind
);
  import mtep_pkg::*;

  result_t res;
  logic    res_ready;

  // Byte register, chunk/event state and the per-byte update.
  mtep_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .res_ready (res_ready),
    .res       (res)
  );

  // Hold each result until the downstream request completes.
  mtep_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
